>>> sv/url_percent_decoder_defines.svh
// Assertion macros shared by the URL percent decoder checker.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Implication checked on the rising clock edge, held off while reset is asserted.
`define UPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/upd_pkg.sv
// Package with the item types, command type and constants of the URL percent decoder.
package upd_pkg;

  // ASCII codes used by the escape decoder.
  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] UpperOff  = 8'h41 - 8'd10;
  localparam logic [7:0] LowerOff  = 8'h61 - 8'd10;

  // Depth of the command queue between front and back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // Most bytes that one input item can release.
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned NumW     = $clog2(MaxBytes + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One queued command: up to three bytes, their count and the end flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NumW-1:0]          num;
    logic                     last;
  } cmd_t;

  // What the front holds back while it waits to decide.
  typedef enum logic [1:0] {
    HeldNone,
    HeldPct,
    HeldDigit
  } held_e;

  // Returns {valid, value} for a hex digit character.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - DigitZero;
      return {1'b1, v[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - UpperOff;
      return {1'b1, v[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - LowerOff;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

>>> sv/upd_front.sv
// Front part: accepts input items, tracks held escape state and issues byte commands.
module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  upd_pkg::in_item_t in_item_i,
  output logic              cmd_push_o,
  output upd_pkg::cmd_t     cmd_o
);

  upd_pkg::held_e state_q, state_d;
  logic [7:0]     digit_char_q, digit_char_d;
  logic [4:0]     in_hex;
  logic [4:0]     held_hex;
  logic           is_hex;
  logic           is_pct;
  logic           last;
  logic [7:0]     b;

  assign b        = in_item_i.in_byte;
  assign last     = in_item_i.in_last;
  assign in_hex   = upd_pkg::hex_val(b);
  assign held_hex = upd_pkg::hex_val(digit_char_q);
  assign is_hex   = in_hex[4];
  assign is_pct   = (b == upd_pkg::PctChar);

  // Next held state for the incoming byte.
  always_comb begin
    state_d      = state_q;
    digit_char_d = digit_char_q;
    if (accept_i) begin
      unique case (state_q)
        upd_pkg::HeldPct: begin
          if (is_hex && !last) begin
            state_d      = upd_pkg::HeldDigit;
            digit_char_d = b;
          end else if (is_pct && !last) begin
            state_d = upd_pkg::HeldPct;
          end else begin
            state_d = upd_pkg::HeldNone;
          end
        end
        upd_pkg::HeldDigit: begin
          if (!is_hex && is_pct && !last) begin
            state_d = upd_pkg::HeldPct;
          end else begin
            state_d = upd_pkg::HeldNone;
          end
        end
        default: begin
          if (is_pct && !last) begin
            state_d = upd_pkg::HeldPct;
          end else begin
            state_d = upd_pkg::HeldNone;
          end
        end
      endcase
    end
  end

  // Bytes released by the incoming byte, in output order.
  always_comb begin
    cmd_o       = '0;
    cmd_o.last  = last;
    unique case (state_q)
      upd_pkg::HeldPct: begin
        if (is_hex && !last) begin
          cmd_o.num = upd_pkg::NumW'(0);
        end else if (is_pct && !last) begin
          cmd_o.num      = upd_pkg::NumW'(1);
          cmd_o.bytes[0] = upd_pkg::PctChar;
        end else begin
          cmd_o.num      = upd_pkg::NumW'(2);
          cmd_o.bytes[0] = upd_pkg::PctChar;
          cmd_o.bytes[1] = b;
        end
      end
      upd_pkg::HeldDigit: begin
        if (is_hex) begin
          cmd_o.num      = upd_pkg::NumW'(1);
          cmd_o.bytes[0] = {held_hex[3:0], in_hex[3:0]};
        end else if (is_pct && !last) begin
          cmd_o.num      = upd_pkg::NumW'(2);
          cmd_o.bytes[0] = upd_pkg::PctChar;
          cmd_o.bytes[1] = digit_char_q;
        end else begin
          cmd_o.num      = upd_pkg::NumW'(3);
          cmd_o.bytes[0] = upd_pkg::PctChar;
          cmd_o.bytes[1] = digit_char_q;
          cmd_o.bytes[2] = b;
        end
      end
      default: begin
        if (is_pct && !last) begin
          cmd_o.num = upd_pkg::NumW'(0);
        end else begin
          cmd_o.num      = upd_pkg::NumW'(1);
          cmd_o.bytes[0] = b;
        end
      end
    endcase
  end

  // An item that releases nothing enqueues no command.
  assign cmd_push_o = accept_i && (cmd_o.num != '0);

  // Held state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= upd_pkg::HeldNone;
      digit_char_q <= 8'd0;
    end else begin
      state_q      <= state_d;
      digit_char_q <= digit_char_d;
    end
  end

endmodule

>>> sv/upd_cmd_fifo.sv
// Short command queue that decouples the front part from the back part.
module upd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output upd_pkg::cmd_t cmd_o
);

  upd_pkg::cmd_t                  mem_q [upd_pkg::FifoDepth];
  logic [upd_pkg::PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [upd_pkg::PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [upd_pkg::CntW-1:0]       count_q, count_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (count_q == upd_pkg::CntW'(upd_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and occupancy update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == upd_pkg::PtrW'(upd_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == upd_pkg::PtrW'(upd_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/upd_back.sv
// Back part: serializes each queued command into output items, one byte per pop.
module upd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  upd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output upd_pkg::out_item_t out_item_o
);

  logic [upd_pkg::NumW-1:0] idx_q, idx_d;
  logic                     final_byte;
  logic                     take;

  assign empty_o    = cmd_empty_i;
  assign take       = pop_i && !cmd_empty_i;
  assign final_byte = (idx_q == cmd_i.num - 1'b1);
  assign cmd_pop_o  = take && final_byte;

  // Select the current byte of the head command.
  always_comb begin
    out_item_o.out_last = cmd_i.last && final_byte;
    unique case (idx_q)
      upd_pkg::NumW'(0): out_item_o.out_byte = cmd_i.bytes[0];
      upd_pkg::NumW'(1): out_item_o.out_byte = cmd_i.bytes[1];
      upd_pkg::NumW'(2): out_item_o.out_byte = cmd_i.bytes[2];
      default:           out_item_o.out_byte = cmd_i.bytes[0];
    endcase
  end

  // Byte index within the head command; restarts when the command retires.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = final_byte ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> sv/url_percent_decoder.sv
// URL percent decoder: a streaming byte decoder for percent escapes.
//
// Input channel: in_item_i carries one byte and an end-of-string flag. An item
// is accepted on a rising edge with push_i high and full_o low.
// Output channel: out_item_o shows the oldest decoded byte while empty_o is low,
// and it is taken on a rising edge with pop_i high and empty_o low.
// The front part keeps a held '%' and hex digit and turns each item into a
// command of zero to three bytes; a four-entry command queue feeds the back
// part, which hands out one byte per pop.
// A command is registered in the queue before its bytes reach out_item_o.
// Throughput: one input item per cycle while the queue has room; output runs
// at one byte per cycle while popped, so two- or three-byte items drain slower.
// When the receiver stalls, results stay put and full_o rises once four
// commands are waiting; items that release no byte never occupy the queue.
// Reset clears the held state and empties the queue; empty_o is high and
// full_o is low after reset.
module url_percent_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  upd_pkg::in_item_t  in_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output upd_pkg::out_item_t out_item_o
);

  logic          accept;
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_empty;
  upd_pkg::cmd_t front_cmd;
  upd_pkg::cmd_t head_cmd;

  assign accept = push_i && !full_o;

  // Front: classify each accepted byte.
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  // Command queue between front and back.
  upd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (head_cmd)
  );

  // Back: emit the queued bytes one at a time.
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> sv/upd_checker.sv
// Port-level checker for the URL percent decoder, bound to the top level.
`include "url_percent_decoder_defines.svh"

module upd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push_i,
  input upd_pkg::in_item_t  in_item_i,
  input logic               full_o,
  input logic               pop_i,
  input logic               empty_o,
  input upd_pkg::out_item_t out_item_o
);

  logic       accept;
  logic       plain_byte;
  logic [4:0] in_hex;

  assign accept     = push_i && !full_o;
  assign in_hex     = upd_pkg::hex_val(in_item_i.in_byte);
  assign plain_byte = !in_hex[4] && (in_item_i.in_byte != upd_pkg::PctChar);

  // A waiting result that is not taken stays unchanged.
  `UPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, !empty_o && !pop_i, $stable(out_item_o) && !empty_o, "output item changed while stalled")

  // The final byte of a string always releases at least one result.
  `UPD_ASSERT_NEXT(a_last_flushes, clk_i, rst_ni, accept && in_item_i.in_last, !empty_o, "end of string released no item")

  // A byte that is neither a percent sign nor a hex digit always releases output.
  `UPD_ASSERT_NEXT(a_plain_emits, clk_i, rst_ni, accept && plain_byte, !empty_o, "plain byte released no item")

endmodule

bind url_percent_decoder upd_checker u_checker (.*);

>>> tb/sv/tb_url_percent_decoder.sv
// Self-checking testbench for the URL percent decoder with a scoreboard class.
`timescale 1ns / 100ps

// Tracks the escape state of the string and holds the decoded bytes still to come.
class percent_decode_scoreboard;
  upd_pkg::out_item_t decoded_q[$];
  upd_pkg::held_e     held_kind;
  logic [3:0]         held_hi;
  logic [7:0]         held_char;
  int                 bytes_in;
  int                 bytes_out;
  int                 escapes_seen;
  int                 strings_seen;
  int                 errors;

  function new();
    clear_held();
    bytes_in     = 0;
    bytes_out    = 0;
    escapes_seen = 0;
    strings_seen = 0;
    errors       = 0;
  endfunction

  function void clear_held();
    held_kind = upd_pkg::HeldNone;
    held_hi   = 4'h0;
    held_char = 8'h00;
  endfunction

  // Value of a hex digit character, or -1 for any other byte.
  function int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function void queue_byte(logic [7:0] b, logic last);
    upd_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = last;
    decoded_q.push_back(r);
    if (last) strings_seen++;
  endfunction

  // A byte seen with nothing held: a percent that is not the end starts an escape.
  function void take_fresh(logic [7:0] b, logic last);
    if (b == upd_pkg::PctChar && !last) begin
      held_kind = upd_pkg::HeldPct;
    end else begin
      queue_byte(b, last);
    end
  endfunction

  // Notes one accepted input item and predicts the bytes it releases.
  function void note_byte_in(upd_pkg::in_item_t it);
    int d;
    d = digit_value(it.in_byte);
    bytes_in++;
    case (held_kind)
      upd_pkg::HeldPct: begin
        if (d >= 0 && !it.in_last) begin
          held_kind = upd_pkg::HeldDigit;
          held_hi   = d[3:0];
          held_char = it.in_byte;
        end else begin
          queue_byte(upd_pkg::PctChar, 1'b0);
          clear_held();
          take_fresh(it.in_byte, it.in_last);
        end
      end
      upd_pkg::HeldDigit: begin
        if (d >= 0) begin
          queue_byte({held_hi, d[3:0]}, it.in_last);
          escapes_seen++;
          clear_held();
        end else begin
          queue_byte(upd_pkg::PctChar, 1'b0);
          queue_byte(held_char, 1'b0);
          clear_held();
          take_fresh(it.in_byte, it.in_last);
        end
      end
      default: begin
        clear_held();
        take_fresh(it.in_byte, it.in_last);
      end
    endcase
  endfunction

  // Compares one accepted result with the oldest predicted byte.
  function void check_byte_out(upd_pkg::out_item_t got);
    upd_pkg::out_item_t want;
    bytes_out++;
    if (decoded_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result %0d: byte %02h last %0b", bytes_out,
                 got.out_byte, got.out_last);
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte || got.out_last !== want.out_last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch at result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                 bytes_out, want.out_byte, want.out_last, got.out_byte, got.out_last);
    end
  endfunction

  function int pending();
    return decoded_q.size();
  endfunction
endclass

module tb_url_percent_decoder;

  localparam int RandomItems = 154;
  localparam int IdlePct     = 11;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push_i;
  upd_pkg::in_item_t  in_item_i;
  logic               full_o;
  logic               pop_i;
  logic               empty_o;
  upd_pkg::out_item_t out_item_o;

  percent_decode_scoreboard sb;
  upd_pkg::in_item_t        string_q[$];
  bit                       steady;
  int                       quiet_cycles;

  url_percent_decoder DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_item_i (in_item_i),
    .full_o    (full_o),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .out_item_o(out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void add_byte(logic [7:0] b, logic last);
    upd_pkg::in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    string_q.push_back(it);
  endfunction

  // Queues a whole string, with the end flag on its final character.
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endfunction

  // Random character, weighted toward percents and hex digits so escapes form often.
  function automatic logic [7:0] pick_char();
    string digits;
    string edges;
    int    r;
    digits = "0123456789ABCDEFabcdef";
    edges  = "/:@G`g";
    r = $urandom_range(99);
    if (r < 30) return upd_pkg::PctChar;
    if (r < 75) return digits[$urandom_range(digits.len() - 1)];
    if (r < 85) return edges[$urandom_range(edges.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Feeds the queued items, idling at random except during a steady stretch.
  task automatic send_items();
    int idx;
    idx = 0;
    while (idx < string_q.size()) begin
      @(posedge clk_i);
      if (push_i && !full_o) begin
        sb.note_byte_in(in_item_i);
        idx++;
      end
      steady = (idx >= 70 && idx < 130);
      if (idx < string_q.size() && (steady || $urandom_range(99) >= IdlePct)) begin
        push_i    <= 1'b1;
        in_item_i <= string_q[idx];
      end else begin
        push_i <= 1'b0;
      end
    end
  endtask

  // Takes decoded bytes and hands them to the scoreboard, stalling at random.
  task automatic take_results();
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_byte_out(out_item_o);
      pop_i <= steady || ($urandom_range(99) >= IdlePct);
    end
  endtask

  // Ends the run if neither side moves for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout after %0d cycles without progress", QuietLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    int len;
    int random_count;
    sb        = new();
    steady    = 1'b0;
    rst_ni    = 1'b0;
    push_i    = 1'b0;
    pop_i     = 1'b0;
    in_item_i = '0;

    // Directed strings: both digit cases, decoded and raw zero bytes, broken escapes,
    // a percent followed by another percent, and percents cut off by the end of string.
    add_text("%4a");
    add_text("%Ff");
    add_byte(upd_pkg::PctChar, 1'b0);
    add_byte("0", 1'b0);
    add_byte("0", 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_text("%g");
    add_text("%Az");
    add_text("%%41");
    add_text("%5%");
    add_text("%");
    add_text("%a");

    // Random strings of one to eight characters.
    random_count = 0;
    while (random_count < RandomItems) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) add_byte(pick_char(), i == len - 1);
      random_count += len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      take_results();
    join_none
    send_items();

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings, checked %0d decoded bytes.",
             sb.bytes_in, sb.strings_seen, sb.bytes_out);
    $display("Escapes decoded: %0d; mismatches: %0d.", sb.escapes_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> url_percent_decoder.f
+incdir+sv
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_cmd_fifo.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
sv/upd_checker.sv
tb/sv/tb_url_percent_decoder.sv
